// ----- sv/iss_pkg.sv -----
// Shared types and constants for the integer set with successor and predecessor search.
`default_nettype none

package iss_pkg;

    localparam int KEY_W            = 8;
    localparam int OP_W             = 2;
    localparam int DEF_UNIVERSE     = 256;
    localparam int DEF_CLUSTER_SIZE = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT      = 2'd0,
        OP_MEMBER      = 2'd1,
        OP_SUCCESSOR   = 2'd2,
        OP_PREDECESSOR = 2'd3
    } iss_op_t;

    typedef struct packed {
        logic [KEY_W-1:0] smallest;
        logic [KEY_W-1:0] largest;
        logic             empty;
    } iss_bounds_t;

    typedef struct packed {
        logic             found;
        logic [KEY_W-1:0] result_key;
    } iss_result_t;

endpackage

`default_nettype wire

// ----- sv/iss_store.sv -----
// Set storage: cluster bit rows, summary of non-empty clusters, and the key bounds.
`default_nettype none

module iss_store #(
    parameter int UNIVERSE     = 256,
    parameter int CLUSTER_SIZE = 16,
    parameter int NUM_CLUSTERS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 insert_en,
    input  wire logic [iss_pkg::KEY_W-1:0]            insert_key,
    output logic [NUM_CLUSTERS-1:0][CLUSTER_SIZE-1:0] rows,
    output logic [NUM_CLUSTERS-1:0]                   summary,
    output iss_pkg::iss_bounds_t                      bounds
);
    import iss_pkg::*;

    localparam int CW  = $clog2(CLUSTER_SIZE);
    localparam int NCW = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;

    logic [NUM_CLUSTERS-1:0][CLUSTER_SIZE-1:0] rows_reg;
    logic [NUM_CLUSTERS-1:0][CLUSTER_SIZE-1:0] rows_next;
    logic [NUM_CLUSTERS-1:0]                   summary_reg;
    logic [NUM_CLUSTERS-1:0]                   summary_next;
    iss_bounds_t                               bounds_reg;
    iss_bounds_t                               bounds_next;

    logic [31:0]      key32;
    logic [31:0]      put32;
    logic [KEY_W-1:0] put_key;
    logic             in_range;
    logic             do_put;
    logic [NCW-1:0]   put_hi;
    logic [CW-1:0]    put_lo;

    always_comb
    begin
        rows_next    = rows_reg;
        summary_next = summary_reg;
        bounds_next  = bounds_reg;
        key32        = 32'(insert_key);
        in_range     = key32 < 32'(UNIVERSE);
        do_put       = 1'b0;
        put_key      = insert_key;

        if (insert_en && in_range)
        begin
            if (bounds_reg.empty)
            begin
                bounds_next.smallest = insert_key;
                bounds_next.largest  = insert_key;
                bounds_next.empty    = 1'b0;
            end
            else if (insert_key != bounds_reg.smallest)
            begin
                do_put = 1'b1;
                // A new minimum displaces the old one into its cluster.
                if (insert_key < bounds_reg.smallest)
                begin
                    bounds_next.smallest = insert_key;
                    put_key              = bounds_reg.smallest;
                end
                if (put_key > bounds_reg.largest)
                begin
                    bounds_next.largest = put_key;
                end
            end
        end

        put32  = 32'(put_key);
        put_hi = NCW'(put32 >> CW);
        put_lo = CW'(put32);

        if (do_put)
        begin
            rows_next[put_hi][put_lo] = 1'b1;
            summary_next[put_hi]      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg            <= '0;
            summary_reg         <= '0;
            bounds_reg.smallest <= '0;
            bounds_reg.largest  <= '0;
            bounds_reg.empty    <= 1'b1;
        end
        else
        begin
            rows_reg    <= rows_next;
            summary_reg <= summary_next;
            bounds_reg  <= bounds_next;
        end
    end

    assign rows    = rows_reg;
    assign summary = summary_reg;
    assign bounds  = bounds_reg;

endmodule

`default_nettype wire

// ----- sv/iss_query.sv -----
// Membership, successor and predecessor search over the cluster rows and summary.
`default_nettype none

module iss_query #(
    parameter int UNIVERSE     = 256,
    parameter int CLUSTER_SIZE = 16,
    parameter int NUM_CLUSTERS = 16
) (
    input  wire logic [iss_pkg::OP_W-1:0]              operation,
    input  wire logic [iss_pkg::KEY_W-1:0]             key,
    input  wire logic [NUM_CLUSTERS-1:0][CLUSTER_SIZE-1:0] rows,
    input  wire logic [NUM_CLUSTERS-1:0]               summary,
    input  wire iss_pkg::iss_bounds_t                  bounds,
    output iss_pkg::iss_result_t                       result
);
    import iss_pkg::*;

    localparam int CW  = $clog2(CLUSTER_SIZE);
    localparam int NCW = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;

    logic [31:0]             key32;
    logic [31:0]             hi32;
    logic [31:0]             lo32;
    logic                    in_range;
    logic                    hi_ok;
    logic [NCW-1:0]          hi_idx;
    logic [CW-1:0]           lo_idx;
    logic [CLUSTER_SIZE-1:0] row_hi;
    logic [CLUSTER_SIZE-1:0] row_up;
    logic [CLUSTER_SIZE-1:0] row_dn;
    logic                    up_hit;
    logic [CW-1:0]           up_pos;
    logic                    dn_hit;
    logic [CW-1:0]           dn_pos;
    logic                    sup_hit;
    logic [NCW-1:0]          sup_idx;
    logic                    sdn_hit;
    logic [NCW-1:0]          sdn_idx;
    logic                    first_hit;
    logic [CW-1:0]           first_pos;
    logic                    last_hit;
    logic [CW-1:0]           last_pos;

    always_comb
    begin
        key32    = 32'(key);
        in_range = key32 < 32'(UNIVERSE);
        hi32     = key32 >> CW;
        lo32     = key32 & 32'(CLUSTER_SIZE - 1);
        hi_ok    = hi32 < 32'(NUM_CLUSTERS);
        hi_idx   = NCW'(hi32);
        lo_idx   = CW'(lo32);
        row_hi   = hi_ok ? rows[hi_idx] : '0;

        up_hit = 1'b0;
        up_pos = '0;
        for (int i = CLUSTER_SIZE - 1; i >= 0; i--)
        begin
            if (row_hi[i] && (32'(i) > lo32))
            begin
                up_hit = 1'b1;
                up_pos = CW'(i);
            end
        end

        dn_hit = 1'b0;
        dn_pos = '0;
        for (int i = 0; i < CLUSTER_SIZE; i++)
        begin
            if (row_hi[i] && (32'(i) < lo32))
            begin
                dn_hit = 1'b1;
                dn_pos = CW'(i);
            end
        end

        sup_hit = 1'b0;
        sup_idx = '0;
        for (int c = NUM_CLUSTERS - 1; c >= 0; c--)
        begin
            if (summary[c] && (32'(c) > hi32))
            begin
                sup_hit = 1'b1;
                sup_idx = NCW'(c);
            end
        end

        sdn_hit = 1'b0;
        sdn_idx = '0;
        for (int c = 0; c < NUM_CLUSTERS; c++)
        begin
            if (summary[c] && (32'(c) < hi32))
            begin
                sdn_hit = 1'b1;
                sdn_idx = NCW'(c);
            end
        end

        row_up = rows[sup_idx];
        row_dn = rows[sdn_idx];

        first_hit = 1'b0;
        first_pos = '0;
        for (int i = CLUSTER_SIZE - 1; i >= 0; i--)
        begin
            if (row_up[i])
            begin
                first_hit = 1'b1;
                first_pos = CW'(i);
            end
        end

        last_hit = 1'b0;
        last_pos = '0;
        for (int i = 0; i < CLUSTER_SIZE; i++)
        begin
            if (row_dn[i])
            begin
                last_hit = 1'b1;
                last_pos = CW'(i);
            end
        end

        result.found      = 1'b0;
        result.result_key = '0;

        case (iss_op_t'(operation))
            OP_INSERT:
            begin
                result.found = in_range;
            end
            OP_MEMBER:
            begin
                result.found = !bounds.empty && in_range
                               && ((key == bounds.smallest) || row_hi[lo_idx]);
            end
            OP_SUCCESSOR:
            begin
                if (!bounds.empty && in_range)
                begin
                    if (key < bounds.smallest)
                    begin
                        result.found      = 1'b1;
                        result.result_key = bounds.smallest;
                    end
                    else if (up_hit)
                    begin
                        result.found      = 1'b1;
                        result.result_key = KEY_W'((hi32 << CW) | 32'(up_pos));
                    end
                    else if (sup_hit && first_hit)
                    begin
                        result.found      = 1'b1;
                        result.result_key = KEY_W'((32'(sup_idx) << CW) | 32'(first_pos));
                    end
                end
            end
            OP_PREDECESSOR:
            begin
                if (!bounds.empty)
                begin
                    if (key > bounds.largest)
                    begin
                        result.found      = 1'b1;
                        result.result_key = bounds.largest;
                    end
                    else if (dn_hit)
                    begin
                        result.found      = 1'b1;
                        result.result_key = KEY_W'((hi32 << CW) | 32'(dn_pos));
                    end
                    else if (sdn_hit && last_hit)
                    begin
                        result.found      = 1'b1;
                        result.result_key = KEY_W'((32'(sdn_idx) << CW) | 32'(last_pos));
                    end
                    else if (bounds.smallest < key)
                    begin
                        result.found      = 1'b1;
                        result.result_key = bounds.smallest;
                    end
                end
            end
            default:
            begin
                result.found      = 1'b0;
                result.result_key = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/integer_set_successor_predecessor.sv -----
// Top level of the integer set with insert, member test, successor and predecessor search.
//
//  Channel  Valid      Stall      Payload
//  -------  ---------  ---------  -------------------
//  request  in_valid   in_stall   operation, key
//  result   out_valid  out_stall  found, result_key
//
// Each request is registered on entry, then searched and applied, and its
// result is registered, so a transaction passes the entry and result registers.
// One request per cycle unless stalled; the single combinational search is the limit.
// Reset empties the set at once; no clearing pass is needed.
// A stall on the result side holds the result register and then the entry register.
`default_nettype none

module integer_set_successor_predecessor #(
    parameter int UNIVERSE     = iss_pkg::DEF_UNIVERSE,
    parameter int CLUSTER_SIZE = iss_pkg::DEF_CLUSTER_SIZE
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [iss_pkg::OP_W-1:0]  operation,
    input  wire logic [iss_pkg::KEY_W-1:0] key,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           found,
    output logic [iss_pkg::KEY_W-1:0]      result_key
);
    import iss_pkg::*;

    localparam int NUM_CLUSTERS = (UNIVERSE + CLUSTER_SIZE - 1) / CLUSTER_SIZE;

    logic                                      in_valid_reg;
    logic [OP_W-1:0]                           op_reg;
    logic [KEY_W-1:0]                          key_reg;
    logic                                      out_valid_reg;
    iss_result_t                               result_reg;
    iss_result_t                               result_next;
    logic                                      out_free;
    logic                                      advance;
    logic                                      take;
    logic                                      insert_en;
    logic [NUM_CLUSTERS-1:0][CLUSTER_SIZE-1:0] rows;
    logic [NUM_CLUSTERS-1:0]                   summary;
    iss_bounds_t                               bounds;

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign take      = in_valid && (!in_valid_reg || advance);
    assign in_stall  = in_valid_reg && !out_free;
    assign insert_en = advance && (iss_op_t'(op_reg) == OP_INSERT);

    iss_store #(
        .UNIVERSE     (UNIVERSE),
        .CLUSTER_SIZE (CLUSTER_SIZE),
        .NUM_CLUSTERS (NUM_CLUSTERS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .insert_en  (insert_en),
        .insert_key (key_reg),
        .rows       (rows),
        .summary    (summary),
        .bounds     (bounds)
    );

    iss_query #(
        .UNIVERSE     (UNIVERSE),
        .CLUSTER_SIZE (CLUSTER_SIZE),
        .NUM_CLUSTERS (NUM_CLUSTERS)
    ) u_query (
        .operation (op_reg),
        .key       (key_reg),
        .rows      (rows),
        .summary   (summary),
        .bounds    (bounds),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg  <= operation;
            key_reg <= key;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = result_reg.found;
    assign result_key = result_reg.result_key;

endmodule

`default_nettype wire
